### hdl/e2q_pkg.sv
// Package for the Euler-to-quaternion block: CORDIC constants and shared types.
// No dependencies.
package e2q_pkg;

  localparam int CW = 34;             // CORDIC x/y width, Q2.30 plus guard
  localparam int ZW = 42;             // angle accumulator, pi = 2^39
  localparam int ATAN_N = 32;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef logic signed [CW-1:0] cs_t;

  typedef struct packed {
    cs_t c;
    cs_t s;
  } cossin_t;

  function automatic logic signed [ZW-1:0] atan_z(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    atan_z = $signed({2'b00, t, 8'h00});
  endfunction

endpackage

### hdl/e2q_cordic.sv
// One pipelined CORDIC lane: cosine and sine of a half angle, one stage per step.
// Depends on e2q_pkg.
module e2q_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic [STEPS:0]                adv,
  input  logic signed [ANGLE_BITS-1:0]  angle,
  output e2q_pkg::cossin_t              cs
);
  import e2q_pkg::*;

  cs_t x_r [STEPS+1];
  cs_t y_r [STEPS+1];
  logic signed [ZW-1:0] z_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= {{(ZW-39){angle[ANGLE_BITS-1]}}, angle, {(39-ANGLE_BITS){1'b0}}};
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv[i+1]) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_z(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_z(i);
        end
      end
    end
  end

  assign cs.c = x_r[STEPS];
  assign cs.s = y_r[STEPS];
endmodule

### hdl/e2q_merge.sv
// Merge stage: pair products, then the four quaternion sums, rounded and saturated.
// Depends on e2q_pkg.
module e2q_merge #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                              clk,
  input  logic [2:0]                        adv,
  input  e2q_pkg::cossin_t                  px,
  input  e2q_pkg::cossin_t                  py,
  input  e2q_pkg::cossin_t                  pz,
  output logic signed [COMPONENT_BITS-1:0]  q_w,
  output logic signed [COMPONENT_BITS-1:0]  q_x,
  output logic signed [COMPONENT_BITS-1:0]  q_y,
  output logic signed [COMPONENT_BITS-1:0]  q_z
);
  import e2q_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SH = 61 - COMPONENT_BITS;

  cs_t cx_r, sx_r, cycz_r, sysz_r, cysz_r, sycz_r;
  logic signed [PW-1:0] m_r [8];
  logic signed [COMPONENT_BITS-1:0] w_r, x_r, y_r, z_r;

  function automatic cs_t rq30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + (PW'(1) <<< 29)) >>> 30;
    rq30 = t[CW-1:0];
  endfunction

  function automatic logic signed [COMPONENT_BITS-1:0] comp(
      input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + ((PW+1)'(1) <<< (SH-1))) >>> SH;
    if (r > (((PW+1)'(1) <<< (COMPONENT_BITS-1)) - (PW+1)'(1)))
      comp = {1'b0, {(COMPONENT_BITS-1){1'b1}}};
    else if (r < -((PW+1)'(1) <<< (COMPONENT_BITS-1)))
      comp = {1'b1, {(COMPONENT_BITS-1){1'b0}}};
    else
      comp = r[COMPONENT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cx_r   <= px.c;
      sx_r   <= px.s;
      cycz_r <= rq30(PW'(py.c) * PW'(pz.c));
      sysz_r <= rq30(PW'(py.s) * PW'(pz.s));
      cysz_r <= rq30(PW'(py.c) * PW'(pz.s));
      sycz_r <= rq30(PW'(py.s) * PW'(pz.c));
    end
    if (adv[1]) begin
      m_r[0] <= PW'(cx_r) * PW'(cycz_r);
      m_r[1] <= PW'(sx_r) * PW'(sysz_r);
      m_r[2] <= PW'(sx_r) * PW'(cycz_r);
      m_r[3] <= PW'(cx_r) * PW'(sysz_r);
      m_r[4] <= PW'(cx_r) * PW'(sycz_r);
      m_r[5] <= PW'(sx_r) * PW'(cysz_r);
      m_r[6] <= PW'(cx_r) * PW'(cysz_r);
      m_r[7] <= PW'(sx_r) * PW'(sycz_r);
    end
    if (adv[2]) begin
      w_r <= comp((PW+1)'(m_r[0]) + (PW+1)'(m_r[1]));
      x_r <= comp((PW+1)'(m_r[2]) - (PW+1)'(m_r[3]));
      y_r <= comp((PW+1)'(m_r[4]) + (PW+1)'(m_r[5]));
      z_r <= comp((PW+1)'(m_r[6]) - (PW+1)'(m_r[7]));
    end
  end

  assign q_w = w_r;
  assign q_x = x_r;
  assign q_y = y_r;
  assign q_z = z_r;
endmodule

### hdl/euler_to_quaternion.sv
// Euler angles to unit quaternion. Accepts one angle triple per cycle while not
// stalled; the pipeline is one input stage plus one stage per CORDIC step in each
// of three parallel lanes, then two multiply stages and a round/saturate stage in
// the merge. It stalls only when a result waits at the output, and then a stage stalls only when its slot is full.
module euler_to_quaternion #(
  parameter int ANGLE_BITS = 16,
  parameter int COMPONENT_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ANGLE_BITS-1:0]      in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]      in_yaw_angle,
  input  logic signed [ANGLE_BITS-1:0]      in_roll_angle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_BITS-1:0]  out_quat_w,
  output logic signed [COMPONENT_BITS-1:0]  out_quat_x,
  output logic signed [COMPONENT_BITS-1:0]  out_quat_y,
  output logic signed [COMPONENT_BITS-1:0]  out_quat_z
);
  import e2q_pkg::*;

  localparam int NS = CORDIC_STEPS + 4;

  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS-1:0] adv;
  cossin_t csx, csy, csz;

  // stage k loads when its slot is free or moving on
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS-2; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_comb begin
    vld_nxt = vld_r;
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++)
      if (adv[k]) vld_nxt[k] = vld_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_lane_x (
    .clk(clk), .adv(adv[CORDIC_STEPS:0]), .angle(in_pitch_angle), .cs(csx));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_lane_y (
    .clk(clk), .adv(adv[CORDIC_STEPS:0]), .angle(in_yaw_angle), .cs(csy));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_lane_z (
    .clk(clk), .adv(adv[CORDIC_STEPS:0]), .angle(in_roll_angle), .cs(csz));

  e2q_merge #(.COMPONENT_BITS(COMPONENT_BITS)) u_merge (
    .clk(clk), .adv(adv[NS-1:NS-3]), .px(csx), .py(csy), .pz(csz),
    .q_w(out_quat_w), .q_x(out_quat_x), .q_y(out_quat_y), .q_z(out_quat_z));

  assign out_valid = vld_r[NS-1];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w) && $stable(out_quat_x))
    else $error("result changed while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ready)
    else $error("ready low with empty input stage");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif
endmodule

### dv/e2q_checker.sv
// Checker for euler_to_quaternion: watches both channels, predicts each quaternion
// from the accepted angle triple (CORDIC half-angle cos/sin, Q30 products, rounding).
// Depends on the block's port widths only.
module e2q_checker #(
  parameter int ANGLE_BITS = 16,
  parameter int COMPONENT_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [ANGLE_BITS-1:0]     in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]     in_yaw_angle,
  input  logic signed [ANGLE_BITS-1:0]     in_roll_angle,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [COMPONENT_BITS-1:0] out_quat_w,
  input  logic signed [COMPONENT_BITS-1:0] out_quat_x,
  input  logic signed [COMPONENT_BITS-1:0] out_quat_y,
  input  logic signed [COMPONENT_BITS-1:0] out_quat_z,
  output int                               fail_count,
  output int                               pending,
  output int                               quat_count
);

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;
  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  quat_t expected_quats[$];

  // >>> on signed longint is an arithmetic (floor) shift
  function automatic void half_cos_sin(input logic signed [ANGLE_BITS-1:0] ang,
                                       output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 64'sd652032874;
    y = 0;
    z = longint'(ang) <<< (39 - ANGLE_BITS);
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]) * 256;
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]) * 256;
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint prod_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic comp_t round_sat(input longint v60);
    longint lim, r;
    lim = 64'sd1 <<< (COMPONENT_BITS - 1);
    r = (v60 + (64'sd1 <<< (60 - COMPONENT_BITS))) >>> (61 - COMPONENT_BITS);
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return comp_t'(r);
  endfunction

  function automatic quat_t predict_quat(input logic signed [ANGLE_BITS-1:0] p,
                                         input logic signed [ANGLE_BITS-1:0] yw,
                                         input logic signed [ANGLE_BITS-1:0] r);
    longint cx, sx, cy, sy, cz, sz, cycz, sysz, cysz, sycz;
    quat_t q;
    half_cos_sin(p, cx, sx);
    half_cos_sin(yw, cy, sy);
    half_cos_sin(r, cz, sz);
    cycz = prod_q30(cy, cz);
    sysz = prod_q30(sy, sz);
    cysz = prod_q30(cy, sz);
    sycz = prod_q30(sy, cz);
    q.w = round_sat(cx * cycz + sx * sysz);
    q.x = round_sat(sx * cycz - cx * sysz);
    q.y = round_sat(cx * sycz + sx * cysz);
    q.z = round_sat(cx * cysz - sx * sycz);
    return q;
  endfunction

  task automatic check_field(input string name, input comp_t exp_v, input comp_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: quat_%s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    quat_count = 0;
  end

  assign pending = expected_quats.size();

  always @(posedge clk) begin
    quat_t q;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_quats.push_back(predict_quat(in_pitch_angle, in_yaw_angle, in_roll_angle));
      if (out_valid && out_ready) begin
        quat_count++;
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected transaction w=%0d x=%0d y=%0d z=%0d", $time,
                   out_quat_w, out_quat_x, out_quat_y, out_quat_z);
          fail_count++;
        end else begin
          q = expected_quats.pop_front();
          check_field("w", q.w, out_quat_w);
          check_field("x", q.x, out_quat_x);
          check_field("y", q.y, out_quat_y);
          check_field("z", q.z, out_quat_z);
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
// Testbench top for euler_to_quaternion: drives angle triples in bursts with a
// stalling receiver and a long hold-off; checking is done in e2q_checker.
module tb_top;

  localparam int AB = 16;
  localparam int CB = 16;
  localparam int N_RANDOM = 1700;
  localparam int WATCHDOG = 5000;
  localparam int DRAIN = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [AB-1:0] in_pitch_angle = '0;
  logic signed [AB-1:0] in_yaw_angle = '0;
  logic signed [AB-1:0] in_roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CB-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  int fail_count, pending, quat_count;
  int idle_cycles = 0;
  int sent = 0;
  bit sending_done = 0;
  bit hold_off = 0;
  logic signed [AB-1:0] angle_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  euler_to_quaternion #(.ANGLE_BITS(AB), .COMPONENT_BITS(CB), .CORDIC_STEPS(16)) uut (.*);

  e2q_checker #(.ANGLE_BITS(AB), .COMPONENT_BITS(CB), .CORDIC_STEPS(16)) chk (.*);

  function automatic logic signed [AB-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return AB'($urandom_range(0, 16)) - 16'sd8;
      3: return 16'sd16384 + AB'($urandom_range(0, 8)) - 16'sd4;
      4: return -16'sd16384 + AB'($urandom_range(0, 8)) - 16'sd4;
      default: return AB'($urandom);
    endcase
  endfunction

  // receiver stall pattern with one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if ((sent / 200) % 3 == 1) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    @(posedge clk);
    wait (sent >= 300);
    @(posedge clk);
    hold_off = 1;
    repeat (150) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int burst, gap;
    logic signed [AB-1:0] corners[6];
    corners = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd16384, -16'sd16384, -16'sd1};
    for (int i = 0; i < 6; i++) begin
      angle_q.push_back(corners[i]);
      angle_q.push_back(corners[(i + 2) % 6]);
      angle_q.push_back(corners[(i + 4) % 6]);
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) angle_q.push_back((i == k) ? -16'sd32768 : 16'sd0);
    for (int i = 0; i < N_RANDOM * 3; i++) angle_q.push_back(rand_angle());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (angle_q.size() >= 3) begin
      burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      for (int b = 0; b < burst && angle_q.size() >= 3; b++) begin
        in_valid <= 1'b1;
        in_pitch_angle <= angle_q.pop_front();
        in_yaw_angle <= angle_q.pop_front();
        in_roll_angle <= angle_q.pop_front();
        do @(posedge clk); while (!in_ready);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d angle triples incl. corner angles, checked %0d quaternions.",
             sent, quat_count);
    if (fail_count == 0 && pending == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

### files.f
hdl/e2q_pkg.sv
hdl/e2q_cordic.sv
hdl/e2q_merge.sv
hdl/euler_to_quaternion.sv
dv/e2q_checker.sv
dv/tb_top.sv
